### rtl/core/qbpc_pkg.sv
// shared types, register indexes and the transition decode for the quadrature counter
package qbpc_pkg;

    // widths fixed by the interface
    localparam int DETENT_W  = 30;
    localparam int BOUND_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int MODE_W    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_MODE = 2'd2;

    // boundary modes, the unused code behaves like no bound action
    localparam logic [MODE_W-1:0] BMODE_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] BMODE_CLAMP = 2'd1;
    localparam logic [MODE_W-1:0] BMODE_WRAP  = 2'd2;

    // item kinds
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_PRESET = 1'b1;

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_UP,
        STEP_DOWN
    } step_t;

    // bound settings as seen by the datapath
    typedef struct packed {
        logic signed [BOUND_W-1:0] min_count;
        logic signed [BOUND_W-1:0] max_count;
        logic [MODE_W-1:0]         mode;
    } bounds_t;

    // x4 decode of {prev_a, prev_b, a, b}
    function automatic step_t step_dir(input logic [3:0] code);
        step_t dir;
        unique case (code)
            4'b1101, 4'b0100, 4'b0010, 4'b1011: dir = STEP_UP;
            4'b1110, 4'b0111, 4'b0001, 4'b1000: dir = STEP_DOWN;
            default:                            dir = STEP_NONE;
        endcase
        return dir;
    endfunction

endpackage

### rtl/core/quadrature_bounded_position_counter_core.sv
// x4 quadrature position counter with configurable bounds: top level
//
// Input channel (s_*): one item per transfer. s_cmd low is a pin sample of
// phases A and B; s_cmd high presets the count to four times s_preset_detent
// when that value lies inside the bounds and the counter range.
// Result channel (m_*): m_detent_value, the count shifted right by two,
// sent whenever the detent index changes and after every preset.
// Config channel (cfg_*): min_count, max_count and boundary_mode at indexes
// 0, 1, 2; write only while no item is in flight. cfg_ready is always high.
// An item passes the input register, then the result register. Throughput:
// one item per cycle while a stalled receiver does not hold an item with a
// result, since the count update that feeds the next item is combinational.
// A stalled receiver holds the result register; the held item in the input
// register then waits if it has a result, and s_ready drops. Items with no
// result pass through even while the receiver stalls.
// Reset (aresetn low, synchronous) clears the count, previous phases, last
// reported detent, the bounds, the mode and both valid flags.
module quadrature_bounded_position_counter_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_cmd,
    input  logic                                 s_phase_a,
    input  logic                                 s_phase_b,
    input  logic signed [qbpc_pkg::DETENT_W-1:0] s_preset_detent,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [qbpc_pkg::DETENT_W-1:0] m_detent_value,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [qbpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qbpc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import qbpc_pkg::*;

    bounds_t                       bounds;

    logic                          in_valid_reg;
    logic                          cmd_reg;
    logic                          phase_a_reg;
    logic                          phase_b_reg;
    logic signed [DETENT_W-1:0]    preset_reg;

    logic [1:0]                    prev_reg;
    logic signed [COUNT_WIDTH-1:0] count_reg;
    logic [DETENT_W-1:0]           last_reg;

    logic                          out_valid_reg;
    logic [DETENT_W-1:0]           out_det_reg;

    logic [1:0]                    prev_next;
    logic signed [COUNT_WIDTH-1:0] count_next;
    logic [DETENT_W-1:0]           det_next;
    logic                          emit;
    logic                          fire;

    qbpc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bounds    (bounds)
    );

    qbpc_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .bounds        (bounds),
        .cmd           (cmd_reg),
        .phase_a       (phase_a_reg),
        .phase_b       (phase_b_reg),
        .preset_detent (preset_reg),
        .prev_phases   (prev_reg),
        .count         (count_reg),
        .last_reported (last_reg),
        .next_phases   (prev_next),
        .next_count    (count_next),
        .next_detent   (det_next),
        .emit          (emit)
    );

    // the held item retires unless its result would hit a full result register
    assign fire    = in_valid_reg && (!emit || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    assign m_valid        = out_valid_reg;
    assign m_detent_value = signed'(out_det_reg);

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg     <= s_cmd;
            phase_a_reg <= s_phase_a;
            phase_b_reg <= s_phase_b;
            preset_reg  <= s_preset_detent;
        end
    end

    // counter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            count_reg <= '0;
            last_reg  <= '0;
        end else if (fire) begin
            prev_reg  <= prev_next;
            count_reg <= count_next;
            last_reg  <= det_next;
        end
    end

    // result register, freed by a transfer and refilled in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            out_det_reg <= det_next;
        end
    end

endmodule

### rtl/core/qbpc_cfg.sv
// configuration registers: bounds and boundary mode
module qbpc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [qbpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qbpc_pkg::CFG_DATA_W-1:0] cfg_data,
    output qbpc_pkg::bounds_t               bounds
);
    import qbpc_pkg::*;

    bounds_t bounds_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign bounds    = bounds_reg;

    // register write on transfer, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bounds_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MIN_COUNT:     bounds_reg.min_count <= signed'(cfg_data);
                CFG_MAX_COUNT:     bounds_reg.max_count <= signed'(cfg_data);
                CFG_BOUNDARY_MODE: bounds_reg.mode      <= cfg_data[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/core/qbpc_step.sv
// next-state logic: transition decode, step, bound action, saturation and preset
module qbpc_step #(
    parameter int COUNT_WIDTH = 32
) (
    input  qbpc_pkg::bounds_t                   bounds,
    input  logic                                cmd,
    input  logic                                phase_a,
    input  logic                                phase_b,
    input  logic signed [qbpc_pkg::DETENT_W-1:0] preset_detent,
    input  logic [1:0]                          prev_phases,
    input  logic signed [COUNT_WIDTH-1:0]       count,
    input  logic [qbpc_pkg::DETENT_W-1:0]       last_reported,
    output logic [1:0]                          next_phases,
    output logic signed [COUNT_WIDTH-1:0]       next_count,
    output logic [qbpc_pkg::DETENT_W-1:0]       next_detent,
    output logic                                emit
);
    import qbpc_pkg::*;

    // common compare width, at least as wide as the bounds
    localparam int W = (COUNT_WIDTH > BOUND_W) ? COUNT_WIDTH : BOUND_W;
    localparam logic signed [W-1:0] ONE_W = W'(1);
    localparam logic signed [COUNT_WIDTH-1:0] HI_CW = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] LO_CW = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam logic signed [W-1:0] HI_W = W'(HI_CW);
    localparam logic signed [W-1:0] LO_W = W'(LO_CW);

    step_t                    dir;
    logic signed [W-1:0]      cnt_ext;
    logic signed [W-1:0]      min_ext;
    logic signed [W-1:0]      max_ext;
    logic signed [W-1:0]      stepped;
    logic signed [W-1:0]      bounded;
    logic signed [W-1:0]      sat;
    logic signed [BOUND_W-1:0] preset_q;
    logic signed [W-1:0]      preset_ext;
    logic                     preset_ok;
    logic signed [W-1:0]      next_ext;

    assign cnt_ext    = W'(count);
    assign min_ext    = W'(bounds.min_count);
    assign max_ext    = W'(bounds.max_count);
    assign preset_q   = {preset_detent, 2'b00};
    assign preset_ext = W'(preset_q);
    assign dir        = step_dir({prev_phases, phase_a, phase_b});

    // step with saturation at the counter range, then the bound action
    always_comb begin
        stepped = cnt_ext;
        bounded = cnt_ext;
        unique case (dir)
            STEP_UP: begin
                stepped = (cnt_ext == HI_W) ? cnt_ext : cnt_ext + ONE_W;
                bounded = stepped;
                if (stepped > max_ext) begin
                    if (bounds.mode == BMODE_CLAMP) begin
                        bounded = max_ext;
                    end else if (bounds.mode == BMODE_WRAP) begin
                        bounded = min_ext;
                    end
                end
            end
            STEP_DOWN: begin
                stepped = (cnt_ext == LO_W) ? cnt_ext : cnt_ext - ONE_W;
                bounded = stepped;
                if (stepped < min_ext) begin
                    if (bounds.mode == BMODE_CLAMP) begin
                        bounded = min_ext;
                    end else if (bounds.mode == BMODE_WRAP) begin
                        bounded = max_ext;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // bound targets may lie outside a narrow counter
    assign sat = (bounded > HI_W) ? HI_W : ((bounded < LO_W) ? LO_W : bounded);

    // preset loads only inside both the bounds and the counter range
    assign preset_ok = (preset_ext >= min_ext) && (preset_ext <= max_ext) &&
                       (preset_ext >= LO_W) && (preset_ext <= HI_W);

    always_comb begin
        if (cmd == CMD_PRESET) begin
            next_count  = preset_ok ? preset_ext[COUNT_WIDTH-1:0] : count;
            next_phases = prev_phases;
        end else begin
            next_count  = sat[COUNT_WIDTH-1:0];
            next_phases = {phase_a, phase_b};
        end
    end

    // detent is the count shifted right by two, low bits kept
    assign next_ext    = W'(next_count);
    assign next_detent = next_ext[DETENT_W+1:2];
    assign emit        = (cmd == CMD_PRESET) || (next_detent != last_reported);

endmodule

### rtl/core/qbpc_checker.sv
// port-level checks for the quadrature counter and their binding
module qbpc_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [qbpc_pkg::DETENT_W-1:0] m_detent_value
);
    import qbpc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_detent_value))
        else $error("result changed or dropped while stalled");

    // reset leaves no result pending and the input open
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result or input stall after reset");

    // a fresh result follows an input transfer through the input and result registers
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without matching input transfer");

endmodule

bind quadrature_bounded_position_counter_core qbpc_checker u_qbpc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_detent_value (m_detent_value)
);
